@@ src/cdst_pkg.sv @@
// Shared types and constants of the C declaration skip tracker.
package cdst_pkg;

	localparam int DEF_STACK_LEVELS = 4;
	localparam int DEF_COUNT_BITS   = 8;

	localparam int TOKEN_LEN_BITS  = 8;
	localparam int TOKEN_TEXT_BITS = 56;

	typedef enum logic [2:0] {
		MODE_INITIAL = 3'd0,
		MODE_TYPEDEF = 3'd1,
		MODE_STRUCT  = 3'd2,
		MODE_CURLY   = 3'd3,
		MODE_ROUND   = 3'd4,
		MODE_DECLARE = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOKEN    = 2'd1,
		ERR_OVERFLOW = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_SET  = 3'd1,
		OP_PUSH = 3'd2,
		OP_POP  = 3'd3,
		OP_INC  = 3'd4,
		OP_DEC  = 3'd5
	} op_t;

	// What the rule logic asks the stack to do with one token.
	typedef struct packed {
		op_t   op;
		mode_t mode;
		err_t  err;
	} action_t;

	// What the stack shows of its top level.
	typedef struct packed {
		mode_t mode;
		logic  count_zero;
		logic  full;
	} top_view_t;

endpackage

@@ src/cdst_rules.sv @@
// Per-state token rules: decide the stack action and error for one token.
module cdst_rules
	import cdst_pkg::*;
(
	input  logic [TOKEN_LEN_BITS-1:0]  token_len,
	input  logic [TOKEN_TEXT_BITS-1:0] token_text,
	input  top_view_t                  view,
	output action_t                    act
);

	// First character sits in the lowest byte.
	localparam logic [55:0] KW_TYPEDEF = {"f", "e", "d", "e", "p", "y", "t"};
	localparam logic [47:0] KW_STRUCT  = {"t", "c", "u", "r", "t", "s"};

	logic [7:0] ch;
	logic       is_one;
	logic       is_typedef;
	logic       is_struct;
	logic       is_alnum;
	action_t    push_round;
	action_t    push_curly;
	action_t    close_act;

	assign ch         = token_text[7:0];
	assign is_one     = (token_len == 8'd1);
	assign is_typedef = (token_len == 8'd7) && (token_text == KW_TYPEDEF);
	assign is_struct  = (token_len == 8'd6) && (token_text[47:0] == KW_STRUCT);
	assign is_alnum   = ch inside {["0":"9"], ["a":"z"], ["A":"Z"]};

	// A push into a full stack is refused and leaves everything as it was.
	assign push_round = view.full
		? action_t'{op: OP_NONE, mode: MODE_INITIAL, err: ERR_OVERFLOW}
		: action_t'{op: OP_PUSH, mode: MODE_ROUND, err: ERR_NONE};
	assign push_curly = view.full
		? action_t'{op: OP_NONE, mode: MODE_INITIAL, err: ERR_OVERFLOW}
		: action_t'{op: OP_PUSH, mode: MODE_CURLY, err: ERR_NONE};
	assign close_act  = action_t'{op: (view.count_zero ? OP_POP : OP_DEC),
	                              mode: MODE_INITIAL, err: ERR_NONE};

	always_comb begin
		act = '{op: OP_NONE, mode: MODE_INITIAL, err: ERR_NONE};
		case (view.mode)
			MODE_INITIAL: begin
				if (is_typedef) begin
					act.op   = OP_SET;
					act.mode = MODE_TYPEDEF;
				end else if (is_one) begin
					act.err = ERR_TOKEN;
				end else begin
					act.op   = OP_SET;
					act.mode = MODE_DECLARE;
				end
			end
			MODE_TYPEDEF: begin
				if (is_struct) begin
					act.op   = OP_SET;
					act.mode = MODE_STRUCT;
				end else if (is_one) begin
					if (ch == ";") act.op = OP_POP;
					else if (ch == "(") act = push_round;
					else act.err = ERR_TOKEN;
				end
			end
			MODE_STRUCT: begin
				if (is_one) begin
					if (ch == ";") act.op = OP_POP;
					else if (ch == "{") act = push_curly;
					else act.err = ERR_TOKEN;
				end
			end
			MODE_DECLARE: begin
				if (is_one) begin
					if (ch == ";") act.op = OP_POP;
					else if (ch == "(") act = push_round;
					else act.err = ERR_TOKEN;
				end
			end
			MODE_CURLY: begin
				if (is_one && !is_alnum) begin
					if (ch == "{") act.op = OP_INC;
					else if (ch == "}") act = close_act;
					else if (!(ch inside {"(", ")", "*", ",", ";", "[", "]"}))
						act.err = ERR_TOKEN;
				end
			end
			MODE_ROUND: begin
				if (is_one) begin
					if (ch == "(") act.op = OP_INC;
					else if (ch == ")") act = close_act;
					else if (!(ch inside {"*", ",", ";"}))
						act.err = ERR_TOKEN;
				end
			end
			default: begin
				act.err = ERR_TOKEN;
			end
		endcase
	end

endmodule

@@ src/cdst_stack.sv @@
// Nesting stack: per-level mode and bracket count, plus the depth pointer.
module cdst_stack
	import cdst_pkg::*;
#(
	parameter int STACK_LEVELS = DEF_STACK_LEVELS,
	parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      apply,
	input  action_t   act,
	output top_view_t view
);

	localparam int DW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

	mode_t                 mode_q  [STACK_LEVELS];
	logic [COUNT_BITS-1:0] count_q [STACK_LEVELS];
	logic [DW-1:0]         depth_q;
	logic [DW-1:0]         depth_up;
	logic [COUNT_BITS-1:0] top_count;

	assign depth_up  = depth_q + DW'(1);
	assign top_count = count_q[depth_q];

	assign view.mode       = mode_q[depth_q];
	assign view.count_zero = (top_count == '0);
	assign view.full       = (depth_q == DW'(STACK_LEVELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STACK_LEVELS; i++) begin
				mode_q[i]  <= MODE_INITIAL;
				count_q[i] <= '0;
			end
			depth_q <= '0;
		end else if (apply && act.err == ERR_NONE) begin
			case (act.op)
				OP_SET: begin
					mode_q[depth_q]  <= act.mode;
					count_q[depth_q] <= '0;
				end
				OP_PUSH: begin
					depth_q           <= depth_up;
					mode_q[depth_up]  <= act.mode;
					count_q[depth_up] <= '0;
				end
				OP_POP: begin
					// At the bottom a pop ends the statement; the count is kept.
					if (depth_q != '0) depth_q <= depth_q - DW'(1);
					else mode_q[0] <= MODE_INITIAL;
				end
				OP_INC: begin
					if (top_count != '1) count_q[depth_q] <= top_count + COUNT_BITS'(1);
				end
				OP_DEC: begin
					count_q[depth_q] <= top_count - COUNT_BITS'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ src/c_declaration_skip_tracker.sv @@
// Top level of the C declaration skip tracker.
//
// Each request on the slave stream carries one C token: s_tdata[7:0] is its
// length and s_tdata[63:8] its first seven bytes, first character lowest.
// For every token one result leaves on the master stream: m_tdata[0] is set
// when the statement has ended (top nesting level is initial), m_tdata[2:1]
// is the error code (none, unexpected token, nesting overflow).
//
// A token is held in an input register, judged against the top of the
// nesting stack, and its result is written to the output register together
// with the stack update. m_tvalid rises when the result is loaded from the
// input register into the output register; one token per cycle is sustained
// while the receiver takes every result, since each step reads and writes
// only the stack top.
//
// When the receiver stalls the result holds and the input register takes
// one more token; s_tready then drops until the result is taken. Reset
// empties both registers and returns every level to the initial state at
// depth zero. An erroneous token leaves the stack untouched.
module c_declaration_skip_tracker
	import cdst_pkg::*;
#(
	parameter int STACK_LEVELS = DEF_STACK_LEVELS,
	parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // token_len[7:0], token_text[63:8]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // statement_done[0], error_code[2:1], zero[7:3]
);

	logic                       valid_s1;
	logic [TOKEN_LEN_BITS-1:0]  len_s1;
	logic [TOKEN_TEXT_BITS-1:0] text_s1;
	logic                       m_valid_q;
	err_t                       err_q;
	logic                       process;
	action_t                    act;
	top_view_t                  view;

	assign process  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || process;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			len_s1  <= s_tdata[TOKEN_LEN_BITS-1:0];
			text_s1 <= s_tdata[TOKEN_LEN_BITS +: TOKEN_TEXT_BITS];
		end
	end

	cdst_rules u_rules (
		.token_len  (len_s1),
		.token_text (text_s1),
		.view       (view),
		.act        (act)
	);

	cdst_stack #(
		.STACK_LEVELS (STACK_LEVELS),
		.COUNT_BITS   (COUNT_BITS)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.apply  (process),
		.act    (act),
		.view   (view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			err_q     <= ERR_NONE;
		end else if (process) begin
			m_valid_q <= 1'b1;
			err_q     <= act.err;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// The stack changes only when a new result is loaded, so the top mode
	// seen now is the state left by the token whose result is on the port.
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, err_q, (view.mode == MODE_INITIAL)};

endmodule

@@ src/cdst_checker.sv @@
// Port-level checks for the C declaration skip tracker, bound to the top level.
module cdst_checker
	import cdst_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// With the output register empty, a new token is always taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output is empty");

	// An overflow comes only from a push inside an open statement.
	a_overflow_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:1] == ERR_OVERFLOW |-> !m_tdata[0])
		else $error("overflow reported with statement ended");

	// Only defined error codes and zero padding leave the block.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:1] <= ERR_OVERFLOW && m_tdata[7:3] == 5'd0)
		else $error("bad result encoding");

endmodule

bind c_declaration_skip_tracker cdst_checker u_cdst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
